// ===== rtl/core/wkas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wkas_pkg
// Types, codes and reset values shared by the winch kicker arming sequencer.
// ----------------------------------------------------------------------------
package wkas_pkg;

   // timer width default
   localparam int TIMER_BITS_DEF = 16;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNWIND_COUNT_LIMIT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNWIND_TIME_TICKS  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRE_HOLD_TICKS    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_TICKS     = 2'd3;

   localparam logic [7:0]  UNWIND_COUNT_LIMIT_RST = 8'd10;
   localparam logic [15:0] UNWIND_TIME_TICKS_RST  = 16'd2000;
   localparam logic [15:0] FIRE_HOLD_TICKS_RST    = 16'd100;
   localparam logic [7:0]  DEBOUNCE_TICKS_RST     = 8'd1;

   // winch drive codes
   localparam logic [1:0] DRV_STOP   = 2'd0;
   localparam logic [1:0] DRV_WIND   = 2'd1;
   localparam logic [1:0] DRV_UNWIND = 2'd2;

   // reported arming state codes
   localparam logic [2:0] CODE_UNKNOWN   = 3'd0;
   localparam logic [2:0] CODE_READY     = 3'd1;
   localparam logic [2:0] CODE_FIRED     = 3'd2;
   localparam logic [2:0] CODE_WINDING   = 3'd3;
   localparam logic [2:0] CODE_WOUND     = 3'd4;
   localparam logic [2:0] CODE_UNWINDING = 3'd5;

   typedef enum logic [5:0] {
      ST_UNKNOWN   = 6'b000001,
      ST_READY     = 6'b000010,
      ST_FIRED     = 6'b000100,
      ST_WINDING   = 6'b001000,
      ST_WOUND     = 6'b010000,
      ST_UNWINDING = 6'b100000
   } arm_state_type;

   // working copy of the arming context while one tick is evaluated
   typedef struct packed {
      arm_state_type state;
      logic [7:0]    edges;
      logic [1:0]    winch;
      logic          wt_clr;   // winch timer cleared during this tick
   } ctx_type;

   // per-tick conditions the state actions look at
   typedef struct packed {
      logic       en;
      logic       armed;
      logic [7:0] cnt_limit;
      logic       t_reached;     // advanced winch timer >= unwind time
      logic       zero_reached;  // cleared winch timer >= unwind time
   } env_type;

   function automatic logic [2:0] state_code(input arm_state_type s);
      logic [2:0] c;
      c = CODE_UNKNOWN;
      unique case (s)
         ST_UNKNOWN:   c = CODE_UNKNOWN;
         ST_READY:     c = CODE_READY;
         ST_FIRED:     c = CODE_FIRED;
         ST_WINDING:   c = CODE_WINDING;
         ST_WOUND:     c = CODE_WOUND;
         ST_UNWINDING: c = CODE_UNWINDING;
         default:      c = CODE_UNKNOWN;
      endcase
      return c;
   endfunction

   function automatic ctx_type transition(input ctx_type c, input env_type e);
      ctx_type r;
      r = c;
      unique case (c.state)
         ST_UNKNOWN: r.state = e.armed ? ST_READY : ST_FIRED;
         ST_READY: begin
            if (!e.armed) r.state = ST_FIRED;
         end
         ST_WINDING: begin
            if (e.armed) r.state = ST_WOUND;
         end
         ST_UNWINDING: begin
            if (r.edges != 8'hFF) r.edges = r.edges + 8'd1;
            if (r.edges >= e.cnt_limit) r.state = ST_READY;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic ctx_type run_state(input ctx_type c, input env_type e);
      ctx_type r;
      logic    reached;
      r = c;
      reached = c.wt_clr ? e.zero_reached : e.t_reached;
      if (e.en) begin
         unique case (c.state)
            ST_UNKNOWN: r = transition(c, e);
            ST_READY:   r.winch = DRV_STOP;
            ST_WINDING: r.winch = DRV_WIND;
            ST_WOUND: begin
               r.winch  = DRV_STOP;
               r.wt_clr = 1'b1;
               r.edges  = 8'd0;
            end
            ST_UNWINDING: begin
               r.winch = DRV_UNWIND;
               if (reached) begin
                  r.winch = DRV_STOP;
                  r.state = ST_READY;
               end
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   function automatic ctx_type try_arm(input ctx_type c, input env_type e);
      ctx_type r;
      r = c;
      if (c.state == ST_FIRED && !e.armed) begin
         r.state = ST_WINDING;
         r = run_state(r, e);
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/winch_kicker_arming_sequencer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// winch_kicker_arming_sequencer_top
// Kicker arming sequencer: one request beat per 1 ms tick in, one response out.
// ----------------------------------------------------------------------------
// usage
//   request channel (req_*): one beat per tick with the armed, cam and winch
//   sensor levels and the fire, arm, unwind and enable commands
//   response channel (rsp_*): one beat per request with the winch drive, the
//   fire motor, the arming state, the fire acknowledge and the unwind edges
//   csr port: write-only, csr_we with csr_index selects unwind count limit,
//   unwind time, fire hold time or debounce time; write only while idle
// latency and throughput
//   a request beat is evaluated in the cycle it is taken and its response is
//   valid the next cycle; one beat per cycle is sustained while rsp_stall is low,
//   set by the single registered pass through the next-state logic
// reset
//   synchronous active-high reset: state unknown, timers and edges zero,
//   motors off, enable history high, csr registers at their default values
// back-pressure
//   the response register holds while rsp_stall is high; a new request is
//   taken whenever that register is empty or being drained in the same cycle
// ----------------------------------------------------------------------------
module winch_kicker_arming_sequencer_top #(
   parameter int TIMER_BITS = wkas_pkg::TIMER_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_armed_closed,
   input  logic                             req_cam_closed,
   input  logic                             req_winch_sensor,
   input  logic                             req_fire_request,
   input  logic                             req_arm_request,
   input  logic                             req_unwind_request,
   input  logic                             req_arming_enable,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_winch_drive,
   output logic                             rsp_fire_motor_on,
   output logic [2:0]                       rsp_arming_state,
   output logic                             rsp_fire_accepted,
   output logic [7:0]                       rsp_unwind_edges,
   // csr write port
   input  logic                             csr_we,
   input  logic [wkas_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [wkas_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // compare width that covers both the timers and the 16-bit limits
   localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

   // csr registers
   logic [7:0]  cnt_limit_ff;
   logic [15:0] unwind_time_ff;
   logic [15:0] fire_hold_ff;
   logic [7:0]  debounce_ff;

   // arming state
   wkas_pkg::arm_state_type state_ff, state_in;
   logic [7:0]            edges_ff, edges_in;
   logic [TIMER_BITS-1:0] winch_tmr_ff, winch_tmr_in;
   logic [TIMER_BITS-1:0] fire_tmr_ff, fire_tmr_in;
   logic [7:0]            deb_tmr_ff, deb_tmr_in;
   logic [2:0]            levels_ff, levels_in;   // bit0 armed, bit1 cam, bit2 winch
   logic                  fire_motor_ff, fire_motor_in;
   logic [1:0]            winch_motor_ff, winch_motor_in;
   logic                  prev_en_ff;

   // response register
   logic       rsp_valid_ff;
   logic [1:0] rsp_drive_ff;
   logic       rsp_fire_ff;
   logic [2:0] rsp_state_ff;
   logic       rsp_acc_ff;
   logic [7:0] rsp_edges_ff;

   logic req_take;
   logic accepted;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;

   // ---------------------------------------------------------------------
   // one tick of the sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      logic [TIMER_BITS-1:0] wt_inc;
      logic [TIMER_BITS-1:0] ft_inc;
      logic [7:0]            dt;
      wkas_pkg::ctx_type     ctx;
      wkas_pkg::env_type     env;

      // saturating timer advance
      wt_inc = (winch_tmr_ff == '1) ? winch_tmr_ff : winch_tmr_ff + TIMER_BITS'(1);
      ft_inc = (fire_tmr_ff == '1) ? fire_tmr_ff : fire_tmr_ff + TIMER_BITS'(1);
      dt     = (deb_tmr_ff == 8'hFF) ? deb_tmr_ff : deb_tmr_ff + 8'd1;

      env.en           = req_arming_enable;
      env.armed        = req_armed_closed;
      env.cnt_limit    = cnt_limit_ff;
      env.t_reached    = CMP_W'(wt_inc) >= CMP_W'(unwind_time_ff);
      env.zero_reached = (unwind_time_ff == 16'd0);

      ctx.state  = state_ff;
      ctx.edges  = edges_ff;
      ctx.winch  = winch_motor_ff;
      ctx.wt_clr = 1'b0;

      fire_motor_in = fire_motor_ff;
      accepted      = 1'b0;

      // enable handling: disabled stops the winch, a rising enable runs the state
      if (!req_arming_enable) begin
         ctx.winch = wkas_pkg::DRV_STOP;
      end else if (!prev_en_ff) begin
         ctx = wkas_pkg::run_state(ctx, env);
      end

      // armed switch edge
      if (req_armed_closed != levels_ff[0]) begin
         ctx = wkas_pkg::transition(ctx, env);
         ctx = wkas_pkg::run_state(ctx, env);
      end

      // debounced winch sensor edge
      if (req_winch_sensor != levels_ff[2]) begin
         if (dt > debounce_ff) begin
            ctx = wkas_pkg::transition(ctx, env);
            ctx = wkas_pkg::run_state(ctx, env);
         end
         dt = 8'd0;
      end

      // cam closing after the fire hold time stops the fire motor and tries to arm
      if (req_cam_closed && !levels_ff[1]) begin
         if (CMP_W'(ft_inc) > CMP_W'(fire_hold_ff)) begin
            fire_motor_in = 1'b0;
            ctx = wkas_pkg::try_arm(ctx, env);
         end
      end

      // commands
      if (req_fire_request && req_armed_closed) begin
         fire_motor_in = 1'b1;
         ctx.state     = wkas_pkg::ST_FIRED;
         ctx           = wkas_pkg::run_state(ctx, env);
         accepted      = 1'b1;
      end
      if (req_arm_request) begin
         ctx = wkas_pkg::try_arm(ctx, env);
      end
      if (req_unwind_request) begin
         ctx.state = wkas_pkg::ST_WOUND;
         ctx       = wkas_pkg::run_state(ctx, env);
         ctx.state = wkas_pkg::ST_UNWINDING;
         ctx       = wkas_pkg::run_state(ctx, env);
      end

      // periodic run
      ctx = wkas_pkg::run_state(ctx, env);

      state_in       = ctx.state;
      edges_in       = ctx.edges;
      winch_motor_in = ctx.winch;
      winch_tmr_in   = ctx.wt_clr ? '0 : wt_inc;
      fire_tmr_in    = accepted ? '0 : ft_inc;
      deb_tmr_in     = dt;
      levels_in      = {req_winch_sensor, req_cam_closed, req_armed_closed};
   end

   // ---------------------------------------------------------------------
   // csr registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_limit_ff   <= wkas_pkg::UNWIND_COUNT_LIMIT_RST;
         unwind_time_ff <= wkas_pkg::UNWIND_TIME_TICKS_RST;
         fire_hold_ff   <= wkas_pkg::FIRE_HOLD_TICKS_RST;
         debounce_ff    <= wkas_pkg::DEBOUNCE_TICKS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            wkas_pkg::CSR_UNWIND_COUNT_LIMIT: cnt_limit_ff   <= csr_wdata[7:0];
            wkas_pkg::CSR_UNWIND_TIME_TICKS:  unwind_time_ff <= csr_wdata;
            wkas_pkg::CSR_FIRE_HOLD_TICKS:    fire_hold_ff   <= csr_wdata;
            wkas_pkg::CSR_DEBOUNCE_TICKS:     debounce_ff    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // arming state, advanced once per taken beat
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= wkas_pkg::ST_UNKNOWN;
         edges_ff       <= 8'd0;
         winch_tmr_ff   <= '0;
         fire_tmr_ff    <= '0;
         deb_tmr_ff     <= 8'd0;
         levels_ff      <= 3'd0;
         fire_motor_ff  <= 1'b0;
         winch_motor_ff <= wkas_pkg::DRV_STOP;
         prev_en_ff     <= 1'b1;
      end else if (req_take) begin
         state_ff       <= state_in;
         edges_ff       <= edges_in;
         winch_tmr_ff   <= winch_tmr_in;
         fire_tmr_ff    <= fire_tmr_in;
         deb_tmr_ff     <= deb_tmr_in;
         levels_ff      <= levels_in;
         fire_motor_ff  <= fire_motor_in;
         winch_motor_ff <= winch_motor_in;
         prev_en_ff     <= req_arming_enable;
      end
   end

   // ---------------------------------------------------------------------
   // response register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_drive_ff <= winch_motor_in;
         rsp_fire_ff  <= fire_motor_in;
         rsp_state_ff <= wkas_pkg::state_code(state_in);
         rsp_acc_ff   <= accepted;
         rsp_edges_ff <= edges_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_winch_drive   = rsp_drive_ff;
   assign rsp_fire_motor_on = rsp_fire_ff;
   assign rsp_arming_state  = rsp_state_ff;
   assign rsp_fire_accepted = rsp_acc_ff;
   assign rsp_unwind_edges  = rsp_edges_ff;

endmodule
